FILE: design/sorted_version_table_top_assert.svh
// ----------------------------------------------------------------------------
// sorted version table assertion macros
// property wrappers on clk with rst as the disable condition
// ----------------------------------------------------------------------------
`ifndef SORTED_VERSION_TABLE_TOP_ASSERT_SVH
`define SORTED_VERSION_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define SVT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg
// types and constants of the sorted version table
// ----------------------------------------------------------------------------
package svt_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VER_W     = 64;
  localparam int VAL_W     = 64;
  localparam int EPOCH_W   = 32;
  localparam int COUNT_W   = 7;

  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_READ   = 2'd1,
    FN_WRITE  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NONE     = 3'd1,
    ST_PENDING  = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_FULL     = 3'd4,
    ST_DUP      = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COL_RD,
    S_COL_WR,
    S_SRCH,
    S_CMP,
    S_EVAL,
    S_SH_RD,
    S_SH_WR,
    S_INS,
    S_DONE
  } state_t;

  typedef struct packed {
    func_t                func;
    logic [VER_W-1:0]     version;
    logic [VAL_W-1:0]     value;
    logic                 dry_run;
    logic [EPOCH_W-1:0]   epoch;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [VAL_W-1:0]     read_value;
    logic [COUNT_W-1:0]   entry_count;
  } out_item_t;

  typedef struct packed {
    logic [VER_W-1:0] version;
    logic [VAL_W-1:0] value;
    logic             pending;
  } entry_t;

endpackage

FILE: design/sorted_version_table_top.sv
// ----------------------------------------------------------------------------
// sorted_version_table_top
// multi-version record table kept sorted by version
// ----------------------------------------------------------------------------
// in_data carries one operation (append, read below, write exact), out_data
// returns one result item per accepted item: status, read value, entry count.
// both channels are valid/ready; in_ready is high only when the sequencer is
// idle, so one item is worked at a time.
// entries live in a single-port-write, registered-read table; one version
// compare unit is reused by a binary search, one table read per step.
// read and write run the binary search and one evaluation step; append adds
// a collection, a shift of each entry above the insert point up one place
// to make room, and the insert. the shift loop sets the worst case.
// a finished result waits in the output register; the next item is taken
// while it waits, and the block holds in its last step until the register
// frees up.
// reset empties the table (entry count zero) and clears the collection
// epoch; table contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_version_table_top #(
  parameter int DEPTH = svt_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  svt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output svt_pkg::out_item_t out_data
);
  import svt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t               mem [DEPTH];
  entry_t               rd_ent;
  logic [AW-1:0]        mem_ra;
  logic [AW-1:0]        mem_wa;
  logic                 mem_we;
  entry_t               mem_wd;

  state_t               state;
  state_t               state_next;
  in_item_t             req;
  logic [CW-1:0]        fill;
  logic [EPOCH_W-1:0]   cepoch;
  logic [CW-1:0]        lo;
  logic [CW-1:0]        hi;
  logic [CW-1:0]        k;
  status_t              res_status;
  logic [VAL_W-1:0]     res_value;

  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid;
  logic [CW-1:0]        lo_dec;
  logic [CW-1:0]        k_dec;
  logic [CW-1:0]        fill_dec;
  logic                 ver_lt;
  logic                 ver_eq;
  logic                 hit;
  logic                 full;
  logic                 out_free;
  logic                 collect;

  // shared compare unit and search arithmetic
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[CW:1];
  assign lo_dec   = lo - 1'b1;
  assign k_dec    = k - 1'b1;
  assign fill_dec = fill - 1'b1;
  assign ver_lt   = rd_ent.version < req.version;
  assign ver_eq   = rd_ent.version == req.version;
  assign hit      = (lo < fill) && ver_eq;
  assign full     = fill >= CW'(DEPTH);
  assign out_free = !out_valid || out_ready;
  assign collect  = (in_data.epoch > cepoch) && (fill >= CW'(2));

  // table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_ent <= mem[mem_ra];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.func) inside
            FN_APPEND: state_next = collect ? S_COL_RD : S_SRCH;
            FN_READ, FN_WRITE: state_next = S_SRCH;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_COL_RD: state_next = S_COL_WR;
      S_COL_WR: state_next = S_SRCH;
      S_SRCH:   state_next = (lo < hi) ? S_CMP : S_EVAL;
      S_CMP:    state_next = S_SRCH;
      S_EVAL: begin
        if (req.func == FN_APPEND && !hit && !full) begin
          state_next = (fill > lo) ? S_SH_RD : S_INS;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SH_RD:  state_next = S_SH_WR;
      S_SH_WR:  state_next = (k_dec > lo) ? S_SH_RD : S_INS;
      S_INS:    state_next = S_DONE;
      S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  // table port control
  always_comb begin
    in_ready = 1'b0;
    mem_ra   = lo[AW-1:0];
    mem_we   = 1'b0;
    mem_wa   = lo[AW-1:0];
    mem_wd   = rd_ent;
    unique case (state)
      S_IDLE:   in_ready = 1'b1;
      S_COL_RD: mem_ra = fill_dec[AW-1:0];
      S_COL_WR: begin
        mem_we = 1'b1;
        mem_wa = '0;
      end
      S_SRCH: begin
        if (lo < hi) begin
          mem_ra = mid[AW-1:0];
        end else if (req.func == FN_READ) begin
          mem_ra = lo_dec[AW-1:0];
        end else begin
          mem_ra = lo[AW-1:0];
        end
      end
      S_EVAL: begin
        if (req.func == FN_WRITE && hit && !req.dry_run) begin
          mem_we = 1'b1;
          mem_wd = '{version: rd_ent.version, value: req.value, pending: 1'b0};
        end
      end
      S_SH_RD:  mem_ra = k_dec[AW-1:0];
      S_SH_WR: begin
        mem_we = 1'b1;
        mem_wa = k[AW-1:0];
      end
      S_INS: begin
        mem_we = 1'b1;
        mem_wd = '{version: req.version, value: '0, pending: 1'b1};
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      cepoch    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req        <= in_data;
            lo         <= '0;
            hi         <= fill;
            res_status <= ST_OK;
            res_value  <= '0;
            if (in_data.func == FN_APPEND && in_data.epoch > cepoch) begin
              cepoch <= in_data.epoch;
            end
          end
        end
        S_COL_WR: begin
          fill <= CW'(1);
          hi   <= CW'(1);
        end
        S_CMP: begin
          if (ver_lt) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
        end
        S_EVAL: begin
          k <= fill;
          case (req.func)
            FN_APPEND: begin
              if (hit) begin
                res_status <= ST_DUP;
              end else if (full) begin
                res_status <= ST_FULL;
              end
            end
            FN_READ: begin
              if (lo == '0) begin
                res_status <= ST_NONE;
              end else if (rd_ent.pending) begin
                res_status <= ST_PENDING;
              end else begin
                res_value <= rd_ent.value;
              end
            end
            FN_WRITE: begin
              if (!hit) begin
                res_status <= ST_MISMATCH;
              end
            end
            default: ;
          endcase
        end
        S_SH_WR: k <= k_dec;
        S_INS:   fill <= fill + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data <= '{status: res_status, read_value: res_value,
                    entry_count: COUNT_W'(fill)};
    end
  end

  `include "sorted_version_table_top_assert.svh"

  `SVT_ASSERT_NOW(a_fill_bound, 1'b1, fill <= CW'(DEPTH), "entry count above depth")
  `SVT_ASSERT_NEXT(a_ins_grows, state == S_INS, fill == CW'($past(fill) + 1'b1), "insert lost count")
  `SVT_ASSERT_NOW(a_shift_above, state == S_SH_WR, k > lo, "shift below insert point")
  `SVT_ASSERT_NEXT(a_collect_one, state == S_COL_WR, fill == CW'(1), "collection left extra entries")

endmodule
